// ===== rtl/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types and constants of the TLV stream header walker.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int unsigned TSW_LENGTH_BITS = 32;

  localparam logic [7:0] PREFIX_WORD16  = 8'd253;
  localparam logic [7:0] PREFIX_WORD32  = 8'd254;
  localparam logic [7:0] PREFIX_INVALID = 8'd255;
  localparam logic [7:0] SHORT_LEN_MASK = 8'h3f;
  localparam int unsigned SHORT_TYPE_SHIFT = 6;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_BYTES  = 3'd2,
    PH_VALUE  = 3'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_VALUE  = 2'd1,
    EV_STATUS = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_PREFIX    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    event_e      event_res;
    logic [31:0] tlv_type;
    logic [31:0] value_length;
    logic        long_form;
    logic [7:0]  value_data;
    logic        value_end;
    logic        packet_done;
    status_e     status;
  } result_t;

endpackage

// ===== rtl/tlv_stream_header_walker.sv =====
// ----------------------------------------------------------------------------
// tlv_stream_header_walker
// Walks a byte stream of type-length-value items and reports headers,
// value bytes and packet errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one packet byte per transfer on s_axis_tdata_i[7:0],
//   s_axis_tlast_i on the packet's final byte.
//   Output stream: at most one result per input byte. m_axis_tuser_o is the
//   event (header, value byte, status only), m_axis_tlast_o closes the packet,
//   m_axis_tdata_o carries the decoded fields. Header prefix bytes and
//   discarded bytes after an unsupported prefix produce no transfer.
//   Path: a byte accepted into the input register is decoded once the result
//   register can take it, and its result is registered there.
//   Throughput: one byte per cycle while the output is not stalled, set by the
//   single decode step between the input register and the result register.
//   Stall: while the result register is full and m_axis_tready_i is low, the
//   input register holds and s_axis_tready_o drops once it is occupied.
//   Reset: both registers empty, the walker waits for a packet's first header.
// ----------------------------------------------------------------------------
module tlv_stream_header_walker import tsw_pkg::*; #(
  parameter int unsigned LENGTH_BITS = TSW_LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [31:0] tlv_type, [63:32] value_length,
                                        // [64] long_form, [72:65] value_data,
                                        // [73] value_end, [75:74] status, rest 0
  output logic [1:0]  m_axis_tuser_o,   // [1:0] event_res
  output logic        m_axis_tlast_o
);

  in_item_t s_item;
  in_item_t item;
  logic     in_valid;
  logic     out_ready;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  res_out;

  assign s_item.data_byte = s_axis_tdata_i;
  assign s_item.last_byte = s_axis_tlast_i;
  assign advance          = in_valid && out_ready;

  tsw_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  tsw_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsw_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res_out)
  );

  assign m_axis_tdata_o = {4'b0000, res_out.status, res_out.value_end, res_out.value_data,
                           res_out.long_form, res_out.value_length, res_out.tlv_type};
  assign m_axis_tuser_o = res_out.event_res;
  assign m_axis_tlast_o = res_out.packet_done;

endmodule

// ===== rtl/tsw_in_stage.sv =====
// ----------------------------------------------------------------------------
// tsw_in_stage
// Input register: holds one byte of the packet until the walker takes it.
// ----------------------------------------------------------------------------
module tsw_in_stage import tsw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_item_t s_item_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  assign s_ready_o = !valid_q || advance_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/tsw_core.sv =====
// ----------------------------------------------------------------------------
// tsw_core
// Header walk state and the per-byte decode step.
// ----------------------------------------------------------------------------
module tsw_core import tsw_pkg::*; #(
  parameter int unsigned LENGTH_BITS = TSW_LENGTH_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  localparam logic [31:0] LenMax = 32'hffff_ffff >> (32 - LENGTH_BITS);

  phase_e                 phase_q, phase_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [31:0]            acc_q, acc_d;
  logic                   rd_len_q, rd_len_d;
  logic [31:0]            held_type_q, held_type_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic                   discard_q, discard_d;
  logic [LENGTH_BITS-1:0] held_len_q, held_len_d;
  logic                   held_long_q, held_long_d;

  always_comb begin
    logic [7:0]             b;
    logic                   last;
    logic                   do_int;
    logic [31:0]            int_val;
    logic                   do_fin;
    logic [31:0]            fin_type;
    logic [LENGTH_BITS-1:0] fin_len;
    logic                   fin_long;
    logic                   do_stat;
    status_e                stat_code;
    logic                   clear;

    b         = item_i.data_byte;
    last      = item_i.last_byte;
    do_int    = 1'b0;
    int_val   = '0;
    do_fin    = 1'b0;
    fin_type  = '0;
    fin_len   = '0;
    fin_long  = 1'b0;
    do_stat   = 1'b0;
    stat_code = ST_OK;
    clear     = 1'b0;

    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    rd_len_d    = rd_len_q;
    held_type_d = held_type_q;
    remain_d    = remain_q;
    discard_d   = discard_q;
    held_len_d  = held_len_q;
    held_long_d = held_long_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (discard_q) begin
      clear = last;
    end else begin
      case (phase_q)
        PH_HEAD: begin
          if (b != 8'd0) begin
            do_fin   = 1'b1;
            fin_type = 32'(b >> SHORT_TYPE_SHIFT);
            fin_len  = LENGTH_BITS'(b & SHORT_LEN_MASK);
          end else begin
            rd_len_d = 1'b0;
            phase_d  = PH_PREFIX;
            if (last) begin
              do_stat   = 1'b1;
              stat_code = ST_TRUNCATED;
            end
          end
        end
        PH_PREFIX: begin
          if (b == PREFIX_INVALID) begin
            do_stat   = 1'b1;
            stat_code = ST_PREFIX;
          end else if (b < PREFIX_WORD16) begin
            do_int  = 1'b1;
            int_val = 32'(b);
          end else begin
            cnt_d   = (b == PREFIX_WORD16) ? 3'd2 : 3'd4;
            acc_d   = '0;
            phase_d = PH_BYTES;
            if (last) begin
              do_stat   = 1'b1;
              stat_code = ST_TRUNCATED;
            end
          end
        end
        PH_BYTES: begin
          acc_d = {acc_q[23:0], b};
          if (cnt_q != 3'd0) begin
            cnt_d = cnt_q - 3'd1;
          end
          if (cnt_d == 3'd0) begin
            do_int  = 1'b1;
            int_val = acc_d;
          end else if (last) begin
            do_stat   = 1'b1;
            stat_code = ST_TRUNCATED;
          end
        end
        PH_VALUE: begin
          if (remain_q != '0) begin
            remain_d = remain_q - LENGTH_BITS'(1);
          end
          res_valid_o        = 1'b1;
          res_o.event_res    = EV_VALUE;
          res_o.tlv_type     = held_type_q;
          res_o.value_length = 32'(held_len_q);
          res_o.long_form    = held_long_q;
          res_o.value_data   = b;
          res_o.value_end    = (remain_d == '0);
          res_o.packet_done  = last;
          if (remain_d == '0) begin
            phase_d = PH_HEAD;
          end else if (last) begin
            res_o.status = ST_TRUNCATED;
          end
          clear = last;
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end

    if (do_int) begin
      if (!rd_len_q) begin
        held_type_d = int_val;
        rd_len_d    = 1'b1;
        phase_d     = PH_PREFIX;
        if (last) begin
          do_stat   = 1'b1;
          stat_code = ST_TRUNCATED;
        end
      end else begin
        do_fin   = 1'b1;
        fin_type = held_type_q;
        fin_len  = (int_val > LenMax) ? LenMax[LENGTH_BITS-1:0] : int_val[LENGTH_BITS-1:0];
        fin_long = 1'b1;
      end
    end

    if (do_fin) begin
      held_type_d        = fin_type;
      held_len_d         = fin_len;
      held_long_d        = fin_long;
      res_valid_o        = 1'b1;
      res_o.event_res    = EV_HEADER;
      res_o.tlv_type     = fin_type;
      res_o.value_length = 32'(fin_len);
      res_o.long_form    = fin_long;
      res_o.packet_done  = last;
      if (fin_len != '0) begin
        remain_d = fin_len;
        phase_d  = PH_VALUE;
        if (last) begin
          res_o.status = ST_TRUNCATED;
        end
      end else begin
        phase_d = PH_HEAD;
      end
      rd_len_d = 1'b0;
      clear    = clear || last;
    end

    if (do_stat) begin
      res_valid_o       = 1'b1;
      res_o             = '0;
      res_o.event_res   = EV_STATUS;
      res_o.packet_done = last;
      res_o.status      = stat_code;
      if (!last && stat_code == ST_PREFIX) begin
        discard_d = 1'b1;
      end else begin
        clear = 1'b1;
      end
    end

    if (clear) begin
      phase_d     = PH_HEAD;
      cnt_d       = '0;
      acc_d       = '0;
      rd_len_d    = 1'b0;
      held_type_d = '0;
      remain_d    = '0;
      discard_d   = 1'b0;
      held_len_d  = '0;
      held_long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      cnt_q       <= '0;
      acc_q       <= '0;
      rd_len_q    <= 1'b0;
      held_type_q <= '0;
      remain_q    <= '0;
      discard_q   <= 1'b0;
      held_len_q  <= '0;
      held_long_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      rd_len_q    <= rd_len_d;
      held_type_q <= held_type_d;
      remain_q    <= remain_d;
      discard_q   <= discard_d;
      held_len_q  <= held_len_d;
      held_long_q <= held_long_d;
    end
  end

endmodule

// ===== rtl/tsw_out_stage.sv =====
// ----------------------------------------------------------------------------
// tsw_out_stage
// Result register toward the downstream stream interface.
// ----------------------------------------------------------------------------
module tsw_out_stage import tsw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// ===== rtl/tsw_checker.sv =====
// ----------------------------------------------------------------------------
// tsw_checker
// Port-level checks of the TLV stream header walker.
// ----------------------------------------------------------------------------
module tsw_checker import tsw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic [1:0] st;
  assign st = m_axis_tdata_o[75:74];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output transfer dropped while stalled");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a stalled output");

  a_trunc_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_TRUNCATED |-> m_axis_tlast_o)
    else $error("truncation reported before packet end");

  a_prefix_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_PREFIX |-> m_axis_tuser_o == EV_STATUS &&
      m_axis_tdata_o[63:0] == 64'd0)
    else $error("unsupported prefix not reported as status only");

  a_value_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[73] |-> m_axis_tuser_o == EV_VALUE && st == ST_OK)
    else $error("value end outside a clean value byte");

endmodule

bind tlv_stream_header_walker tsw_checker u_tsw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
